FILE: src/qfdon_pkg.sv
// Shared types and constants for the quad face dof numbering block.
package qfdon_pkg;

  localparam int NODE_W = 31;
  localparam int ADDR_W = 32;
  localparam int CNT_W  = 6;
  localparam int DIM_W  = 3;

  localparam logic [3:0]       MAX_DEGREE      = 4'd8;
  localparam logic [3:0]       MAX_LOCAL_FACES = 4'd12;
  localparam logic [CNT_W-1:0] MAX_RESULTS     = 6'd49;

  // configuration register indexes
  localparam logic [2:0] REG_FACE_DEGREE   = 3'd0;
  localparam logic [2:0] REG_DOFS_PER_FACE = 3'd1;
  localparam logic [2:0] REG_DOF_ORIGIN    = 3'd2;
  localparam logic [2:0] REG_OUT_BASE      = 3'd3;
  localparam logic [2:0] REG_OUT_STRIDE    = 3'd4;

  // orientation codes
  localparam logic signed [3:0] ORIENT_P1 = 4'sd1;
  localparam logic signed [3:0] ORIENT_P2 = 4'sd2;
  localparam logic signed [3:0] ORIENT_P3 = 4'sd3;
  localparam logic signed [3:0] ORIENT_P4 = 4'sd4;
  localparam logic signed [3:0] ORIENT_N1 = -4'sd1;
  localparam logic signed [3:0] ORIENT_N2 = -4'sd2;
  localparam logic signed [3:0] ORIENT_N3 = -4'sd3;
  localparam logic signed [3:0] ORIENT_N4 = -4'sd4;

  // configuration as seen by the datapath, with derived sizes
  typedef struct packed {
    logic [DIM_W-1:0]  n;        // interior dofs per side
    logic [CNT_W-1:0]  count;    // results per face
    logic [CNT_W-1:0]  dofs;     // dofs_per_face register
    logic [ADDR_W-1:0] origin;
    logic [ADDR_W-1:0] base;
    logic [15:0]       stride;
  } cfg_t;

  // one oriented face handed to the dof walker
  typedef struct packed {
    logic signed [3:0] code;
    logic [ADDR_W-1:0] slot0;
    logic [ADDR_W-1:0] dof0;
  } item_t;

endpackage

FILE: src/qfdon_front.sv
// Three-stage front end: capture, rotate and multiply, orientation code and base sums.
module qfdon_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [qfdon_pkg::NODE_W-1:0]        corner_a,
  input  logic [qfdon_pkg::NODE_W-1:0]        corner_b,
  input  logic [qfdon_pkg::NODE_W-1:0]        corner_c,
  input  logic [qfdon_pkg::NODE_W-1:0]        corner_d,
  input  logic [qfdon_pkg::NODE_W-1:0]        face_number,
  input  logic [qfdon_pkg::NODE_W-1:0]        cell_number,
  input  logic [3:0]                          local_face,
  input  qfdon_pkg::cfg_t                     cfg,
  input  logic                                item_ready,
  output logic                                item_valid,
  output qfdon_pkg::item_t                    item
);

  // stage 1: captured word
  logic                              s1_valid;
  logic [qfdon_pkg::NODE_W-1:0]      s1_node [4];
  logic [qfdon_pkg::NODE_W-1:0]      s1_face;
  logic [qfdon_pkg::NODE_W-1:0]      s1_cell;
  logic [3:0]                        s1_lf;

  // stage 2: rotated corners and products
  logic                              s2_valid;
  logic [qfdon_pkg::NODE_W-1:0]      s2_rot  [4];
  logic [qfdon_pkg::NODE_W-1:0]      s2_orig [4];
  logic [qfdon_pkg::ADDR_W-1:0]      s2_cell_prod;
  logic [qfdon_pkg::ADDR_W-1:0]      s2_base_lf;
  logic [qfdon_pkg::ADDR_W-1:0]      s2_face_prod;

  // stage 3: finished item
  logic                              s3_valid;
  qfdon_pkg::item_t                  s3_item;

  logic                              s1_keep;
  logic                              s1_en, s2_en, s3_en;
  logic                              accept;
  logic [3:0]                        is_min;
  logic [1:0]                        shift;
  logic [qfdon_pkg::NODE_W-1:0]      rot [4];
  logic [46:0]                       cell_prod;
  logic [36:0]                       face_prod;
  logic [9:0]                        lf_prod;
  logic signed [3:0]                 code_raw;
  logic signed [3:0]                 code;

  // faces with a bad slot or no dofs are dropped leaving stage 1
  assign s1_keep = (s1_lf < qfdon_pkg::MAX_LOCAL_FACES) && (cfg.count != '0);

  assign s3_en  = !s3_valid || item_ready;
  assign s2_en  = !s2_valid || s3_en;
  assign s1_en  = !s1_valid || !s1_keep || s2_en;
  assign busy   = !s1_en;
  assign accept = start && !busy;

  assign item_valid = s3_valid;
  assign item       = s3_item;

  // strict-minimum search: corner k is the first one strictly below the others
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      is_min[k] = (s1_node[k] < s1_node[2'(k + 1)]) &&
                  (s1_node[k] < s1_node[2'(k + 2)]) &&
                  (s1_node[k] < s1_node[2'(k + 3)]);
    end
    priority if (is_min[0]) shift = 2'd0;
    else if (is_min[1])     shift = 2'd1;
    else if (is_min[2])     shift = 2'd2;
    else if (is_min[3])     shift = 2'd3;
    else                    shift = 2'd0;   // full turn: original order
    for (int i = 0; i < 4; i++) begin
      rot[i] = s1_node[2'(i) + shift];
    end
  end

  assign cell_prod = 47'(s1_cell) * 47'(cfg.stride);
  assign face_prod = 37'(s1_face) * 37'(cfg.dofs);
  assign lf_prod   = 10'(s1_lf) * 10'(cfg.dofs);

  // first match of the rotated corners against the original order
  always_comb begin
    priority if (s2_rot[0] == s2_orig[0] && s2_rot[1] == s2_orig[1] &&
                 s2_rot[2] == s2_orig[2] && s2_rot[3] == s2_orig[3])
      code_raw = qfdon_pkg::ORIENT_P1;
    else if (s2_rot[0] == s2_orig[1] && s2_rot[1] == s2_orig[2] &&
             s2_rot[2] == s2_orig[3] && s2_rot[3] == s2_orig[0])
      code_raw = qfdon_pkg::ORIENT_P2;
    else if (s2_rot[0] == s2_orig[2] && s2_rot[1] == s2_orig[3] &&
             s2_rot[2] == s2_orig[0] && s2_rot[3] == s2_orig[1])
      code_raw = qfdon_pkg::ORIENT_P3;
    else if (s2_rot[0] == s2_orig[3] && s2_rot[1] == s2_orig[0] &&
             s2_rot[2] == s2_orig[1] && s2_rot[3] == s2_orig[2])
      code_raw = qfdon_pkg::ORIENT_P4;
    else if (s2_rot[0] == s2_orig[0] && s2_rot[1] == s2_orig[3] &&
             s2_rot[2] == s2_orig[2] && s2_rot[3] == s2_orig[1])
      code_raw = qfdon_pkg::ORIENT_N1;
    else if (s2_rot[0] == s2_orig[1] && s2_rot[1] == s2_orig[0] &&
             s2_rot[2] == s2_orig[3] && s2_rot[3] == s2_orig[2])
      code_raw = qfdon_pkg::ORIENT_N2;
    else if (s2_rot[0] == s2_orig[2] && s2_rot[1] == s2_orig[1] &&
             s2_rot[2] == s2_orig[0] && s2_rot[3] == s2_orig[3])
      code_raw = qfdon_pkg::ORIENT_N3;
    else if (s2_rot[0] == s2_orig[3] && s2_rot[1] == s2_orig[2] &&
             s2_rot[2] == s2_orig[1] && s2_rot[3] == s2_orig[0])
      code_raw = qfdon_pkg::ORIENT_N4;
    else
      code_raw = qfdon_pkg::ORIENT_P1;
    // mirrored when rotated corner 1 exceeds rotated corner 3
    code = (s2_rot[1] > s2_rot[3]) ? -code_raw : code_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_en) s1_valid <= accept;
      if (s2_en) s2_valid <= s1_valid && s1_keep;
      if (s3_en) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_node[0] <= corner_a;
      s1_node[1] <= corner_b;
      s1_node[2] <= corner_c;
      s1_node[3] <= corner_d;
      s1_face    <= face_number;
      s1_cell    <= cell_number;
      s1_lf      <= local_face;
    end
    if (s2_en) begin
      for (int i = 0; i < 4; i++) begin
        s2_rot[i]  <= rot[i];
        s2_orig[i] <= s1_node[i];
      end
      s2_cell_prod <= cell_prod[31:0];
      s2_face_prod <= face_prod[31:0];
      s2_base_lf   <= cfg.base + 32'(lf_prod);
    end
    if (s3_en) begin
      s3_item.code  <= code;
      s3_item.slot0 <= s2_base_lf + s2_cell_prod;
      s3_item.dof0  <= cfg.origin + s2_face_prod;
    end
  end

endmodule

FILE: src/qfdon_emit.sv
// Dof walker: one result word per cycle from an oriented face.
module qfdon_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  qfdon_pkg::cfg_t                cfg,
  input  logic                           item_valid,
  input  qfdon_pkg::item_t               item,
  output logic                           item_ready,
  output logic                           dof_valid,
  output logic [qfdon_pkg::ADDR_W-1:0]   table_slot,
  output logic [qfdon_pkg::ADDR_W-1:0]   dof_number,
  output logic signed [3:0]              orient_code,
  output logic                           last_dof
);

  logic                            active;
  qfdon_pkg::item_t                cur;
  logic [qfdon_pkg::CNT_W-1:0]     d;
  logic [qfdon_pkg::DIM_W-1:0]     a, b;     // row and column, zero based
  logic [qfdon_pkg::DIM_W-1:0]     m;
  logic [qfdon_pkg::DIM_W-1:0]     rr, ss;
  logic [qfdon_pkg::CNT_W-1:0]     perm;
  logic                            em_last;
  logic                            load;

  assign m          = cfg.n - 3'd1;
  assign em_last    = active && (d == cfg.count - 6'd1);
  assign item_ready = !active || em_last;
  assign load       = item_valid && item_ready;

  always_comb begin
    unique case (cur.code)
      qfdon_pkg::ORIENT_P1: begin rr = b;     ss = a;     end
      qfdon_pkg::ORIENT_N2: begin rr = b;     ss = m - a; end
      qfdon_pkg::ORIENT_N3: begin rr = m - a; ss = m - b; end
      qfdon_pkg::ORIENT_N4: begin rr = m - b; ss = a;     end
      qfdon_pkg::ORIENT_N1: begin rr = a;     ss = b;     end
      qfdon_pkg::ORIENT_P2: begin rr = m - a; ss = b;     end
      qfdon_pkg::ORIENT_P3: begin rr = m - b; ss = m - a; end
      qfdon_pkg::ORIENT_P4: begin rr = a;     ss = m - b; end
      default:              begin rr = a;     ss = b;     end
    endcase
    perm = 6'(cfg.n) * 6'(rr) + 6'(ss);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      dof_valid <= 1'b0;
    end else begin
      dof_valid <= active;
      if (load)         active <= 1'b1;
      else if (em_last) active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      table_slot  <= cur.slot0 + 32'(d);
      dof_number  <= cur.dof0 + 32'(perm);
      orient_code <= cur.code;
      last_dof    <= em_last;
    end
    if (load) begin
      cur <= item;
      d   <= '0;
      a   <= '0;
      b   <= '0;
    end else if (active) begin
      d <= d + 6'd1;
      if (b == m) begin
        b <= '0;
        a <= a + 3'd1;
      end else begin
        b <= b + 3'd1;
      end
    end
  end

endmodule

FILE: src/quad_face_dof_orientation_numbering_top.sv
// Top level of the quad face interior dof numbering block.
//
//  channel   | handshake              | word
//  ----------+------------------------+-------------------------------------------
//  input     | start & !busy          | corner_a..d, face_number, cell_number,
//            |                        | local_face
//  config    | cfg_we (no wait)       | cfg_idx selects register, cfg_data
//  result    | dof_valid, one cycle   | table_slot, dof_number, orient_code,
//            |                        | last_dof
//
// Three front stages (capture; rotation and products; code and base sums) feed the
// dof walker: min(dofs_per_face, (degree-1)^2) words per face, up to 49, one a cycle.
// Faces pass the registered front stages and walker; result words are registered.
// The walker sets the rate; the next face follows with no gap. Faces with no
// dofs or a bad local slot give no words. Reset clears valid bits, loads defaults.
// The receiver cannot stall; busy rises only when the front is full behind the walker.
module quad_face_dof_orientation_numbering_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [qfdon_pkg::NODE_W-1:0]   corner_a,
  input  logic [qfdon_pkg::NODE_W-1:0]   corner_b,
  input  logic [qfdon_pkg::NODE_W-1:0]   corner_c,
  input  logic [qfdon_pkg::NODE_W-1:0]   corner_d,
  input  logic [qfdon_pkg::NODE_W-1:0]   face_number,
  input  logic [qfdon_pkg::NODE_W-1:0]   cell_number,
  input  logic [3:0]                     local_face,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_idx,
  input  logic [31:0]                    cfg_data,
  output logic                           dof_valid,
  output logic [qfdon_pkg::ADDR_W-1:0]   table_slot,
  output logic [qfdon_pkg::ADDR_W-1:0]   dof_number,
  output logic signed [3:0]              orient_code,
  output logic                           last_dof
);

  // configuration registers
  logic [3:0]                    face_degree;
  logic [qfdon_pkg::CNT_W-1:0]   dofs_per_face;
  logic [31:0]                   dof_origin;
  logic [31:0]                   out_base;
  logic [15:0]                   out_stride;

  logic [3:0]                    deg_sat;
  logic [qfdon_pkg::DIM_W-1:0]   n;
  logic [qfdon_pkg::CNT_W-1:0]   nsq;
  logic [qfdon_pkg::CNT_W-1:0]   cnt_min;
  qfdon_pkg::cfg_t               cfg;
  logic                          item_valid, item_ready;
  qfdon_pkg::item_t              item;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_degree   <= 4'd2;
      dofs_per_face <= 6'd1;
      dof_origin    <= '0;
      out_base      <= '0;
      out_stride    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        qfdon_pkg::REG_FACE_DEGREE:   face_degree   <= cfg_data[3:0];
        qfdon_pkg::REG_DOFS_PER_FACE: dofs_per_face <= cfg_data[5:0];
        qfdon_pkg::REG_DOF_ORIGIN:    dof_origin    <= cfg_data;
        qfdon_pkg::REG_OUT_BASE:      out_base      <= cfg_data;
        qfdon_pkg::REG_OUT_STRIDE:    out_stride    <= cfg_data[15:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // degree saturates; below two there are no interior dofs
  always_comb begin
    deg_sat = (face_degree > qfdon_pkg::MAX_DEGREE) ? qfdon_pkg::MAX_DEGREE : face_degree;
    n       = (deg_sat >= 4'd2) ? 3'(deg_sat - 4'd1) : '0;
    nsq     = 6'(n) * 6'(n);
    cnt_min = (dofs_per_face > nsq) ? nsq : dofs_per_face;
    cfg.n      = n;
    cfg.count  = (cnt_min > qfdon_pkg::MAX_RESULTS) ? qfdon_pkg::MAX_RESULTS : cnt_min;
    cfg.dofs   = dofs_per_face;
    cfg.origin = dof_origin;
    cfg.base   = out_base;
    cfg.stride = out_stride;
  end

  qfdon_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .corner_a    (corner_a),
    .corner_b    (corner_b),
    .corner_c    (corner_c),
    .corner_d    (corner_d),
    .face_number (face_number),
    .cell_number (cell_number),
    .local_face  (local_face),
    .cfg         (cfg),
    .item_ready  (item_ready),
    .item_valid  (item_valid),
    .item        (item)
  );

  qfdon_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .item        (item),
    .item_ready  (item_ready),
    .dof_valid   (dof_valid),
    .table_slot  (table_slot),
    .dof_number  (dof_number),
    .orient_code (orient_code),
    .last_dof    (last_dof)
  );

endmodule

FILE: src/qfdon_check.sv
// Port-level checker for the quad face dof numbering block, with its bind.
module qfdon_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           dof_valid,
  input logic [qfdon_pkg::ADDR_W-1:0]   table_slot,
  input logic signed [3:0]              orient_code,
  input logic                           last_dof
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !dof_valid)
    else $error("result word right after reset");

  a_code_nonzero: assert property (@(posedge clk) disable iff (rst)
    dof_valid |-> orient_code != 4'sd0)
    else $error("orientation code zero");

  a_face_no_gap: assert property (@(posedge clk) disable iff (rst)
    dof_valid && !last_dof |=> dof_valid)
    else $error("gap inside a face");

  a_slot_step: assert property (@(posedge clk) disable iff (rst)
    dof_valid && !last_dof |=> table_slot == $past(table_slot) + 32'd1)
    else $error("table slot not consecutive within a face");

  a_code_hold: assert property (@(posedge clk) disable iff (rst)
    dof_valid && !last_dof |=> orient_code == $past(orient_code))
    else $error("orientation code changed within a face");

endmodule

bind quad_face_dof_orientation_numbering_top qfdon_check u_qfdon_check (
  .clk         (clk),
  .rst         (rst),
  .dof_valid   (dof_valid),
  .table_slot  (table_slot),
  .orient_code (orient_code),
  .last_dof    (last_dof)
);
